/* hw/rtl/wbrl_pkg.sv */
// ----------------------------------------------------------------------------
// wbrl_pkg
// shared types and codes for the width budget recency list
// ----------------------------------------------------------------------------
package wbrl_pkg;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 6;
  localparam int IN_WID_W = 16;
  localparam int BUDGET_W = 20;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UNL_RD,
    S_UNL,
    S_LINK_A,
    S_LINK_B,
    S_AWALK,
    S_EVICT,
    S_RSTART,
    S_RWALK
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_RD_ID,
    OP_UNLINK,
    OP_LINK_A,
    OP_LINK_B,
    OP_AWALK,
    OP_EVICT,
    OP_RSTART,
    OP_RWALK
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             id_ok;
    logic             present;
    logic             at_nil;
    logic             over;
  } status_t;

endpackage

/* hw/rtl/wbrl_ctrl.sv */
// ----------------------------------------------------------------------------
// wbrl_ctrl
// sequencer for add, remove and report commands
// ----------------------------------------------------------------------------
module wbrl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  wbrl_pkg::status_t st,
  output wbrl_pkg::op_t    op
);
  import wbrl_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op        = OP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_IDLE;
        if (st.cmd == CMD_ADD && st.id_ok) begin
          state_nxt = st.present ? S_UNL_RD : S_LINK_A;
        end else if (st.cmd == CMD_REMOVE && st.id_ok && st.present) begin
          state_nxt = S_UNL_RD;
        end else if (st.cmd == CMD_REPORT) begin
          state_nxt = S_RSTART;
        end
      end
      S_UNL_RD: begin
        op        = OP_RD_ID;
        state_nxt = S_UNL;
      end
      S_UNL: begin
        op        = OP_UNLINK;
        state_nxt = (st.cmd == CMD_ADD) ? S_LINK_A : S_IDLE;
      end
      S_LINK_A: begin
        op        = OP_LINK_A;
        state_nxt = S_LINK_B;
      end
      S_LINK_B: begin
        op        = OP_LINK_B;
        state_nxt = S_AWALK;
      end
      S_AWALK: begin
        op = OP_AWALK;
        if (st.at_nil)    state_nxt = S_IDLE;
        else if (st.over) state_nxt = S_EVICT;
      end
      S_EVICT: begin
        op = OP_EVICT;
        if (st.at_nil) state_nxt = S_IDLE;
      end
      S_RSTART: begin
        op        = OP_RSTART;
        state_nxt = S_RWALK;
      end
      S_RWALK: begin
        op = OP_RWALK;
        if (st.at_nil || st.over) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* hw/rtl/wbrl_datapath.sv */
// ----------------------------------------------------------------------------
// wbrl_datapath
// link memories, presence bits, head pointer, walk registers and result regs
// ----------------------------------------------------------------------------
module wbrl_datapath #(
  parameter int NUM_IDS    = 64,
  parameter int WIDTH_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wbrl_pkg::op_t                 op,
  output wbrl_pkg::status_t             st,
  input  logic [wbrl_pkg::CMD_W-1:0]    in_cmd,
  input  logic [wbrl_pkg::ID_W-1:0]     in_entry_id,
  input  logic [wbrl_pkg::IN_WID_W-1:0] in_entry_width,
  input  logic                          cfg_we,
  input  logic [wbrl_pkg::BUDGET_W-1:0] cfg_wdata,
  output logic                          out_valid,
  output logic [wbrl_pkg::ID_W-1:0]     out_report_id,
  output logic                          out_list_empty,
  output logic                          out_last_of_report
);
  import wbrl_pkg::*;

  localparam int IDW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int LW  = $clog2(NUM_IDS + 1);
  localparam int SW  = (WIDTH_BITS + LW > BUDGET_W) ? WIDTH_BITS + LW : BUDGET_W;
  localparam logic [LW-1:0] NIL = LW'(NUM_IDS);

  // link and width memories
  logic [LW-1:0]         next_mem [NUM_IDS];
  logic [LW-1:0]         prev_mem [NUM_IDS];
  logic [WIDTH_BITS-1:0] wid_mem  [NUM_IDS];

  logic [NUM_IDS-1:0]    present_r;
  logic [CMD_W-1:0]      cmd_r;
  logic [ID_W-1:0]       id_r;
  logic [WIDTH_BITS-1:0] w_r;
  logic [BUDGET_W-1:0]   budget_r;
  logic [LW-1:0]         head_r, old_head_r, cur_r, pred_r;
  logic [LW-1:0]         rd_next_q, rd_prev_q;
  logic [WIDTH_BITS-1:0] rd_w_q;
  logic [SW-1:0]         sum_r;
  logic                  pend_valid_r;
  logic [IDW-1:0]        pend_id_r;

  logic [LW-1:0]         rd_addr, id_link;
  logic [SW-1:0]         sum_add;
  logic                  at_nil, over;
  logic [47:0]           w_ext;

  logic                  nw_en, pw_en, ww_en;
  logic [LW-1:0]         nw_addr, nw_data, pw_addr, pw_data;

  assign w_ext   = {32'b0, in_entry_width};
  assign id_link = LW'(id_r[IDW-1:0]);
  assign at_nil  = (cur_r == NIL);
  assign sum_add = sum_r + SW'(rd_w_q);
  assign over    = (sum_add > SW'(budget_r));

  assign st.cmd     = cmd_r;
  assign st.id_ok   = ({1'b0, id_r} < 7'(NUM_IDS));
  assign st.present = present_r[id_r[IDW-1:0]];
  assign st.at_nil  = at_nil;
  assign st.over    = over;

  // read address: walks follow the registered next link
  always_comb begin
    case (op)
      OP_RD_ID:             rd_addr = id_link;
      OP_LINK_B, OP_RSTART: rd_addr = head_r;
      default:              rd_addr = rd_next_q;
    endcase
  end

  // write ports
  always_comb begin
    nw_en   = 1'b0;
    nw_addr = rd_prev_q;
    nw_data = rd_next_q;
    pw_en   = 1'b0;
    pw_addr = rd_next_q;
    pw_data = rd_prev_q;
    ww_en   = 1'b0;
    case (op)
      OP_UNLINK: begin
        nw_en = (rd_prev_q != NIL);
        pw_en = (rd_next_q != NIL);
      end
      OP_LINK_A: begin
        nw_en   = 1'b1;
        nw_addr = id_link;
        nw_data = head_r;
        pw_en   = 1'b1;
        pw_addr = id_link;
        pw_data = NIL;
        ww_en   = 1'b1;
      end
      OP_LINK_B: begin
        pw_en   = (old_head_r != NIL);
        pw_addr = old_head_r;
        pw_data = id_link;
      end
      OP_AWALK: begin
        // cut the list after the last entry that fits
        nw_en   = !at_nil && over && (pred_r != NIL);
        nw_addr = pred_r;
        nw_data = NIL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nw_en) next_mem[nw_addr[IDW-1:0]] <= nw_data;
    if (pw_en) prev_mem[pw_addr[IDW-1:0]] <= pw_data;
    if (ww_en) wid_mem[id_r[IDW-1:0]]     <= w_r;
    rd_next_q <= next_mem[rd_addr[IDW-1:0]];
    rd_prev_q <= prev_mem[rd_addr[IDW-1:0]];
    rd_w_q    <= wid_mem[rd_addr[IDW-1:0]];
    cur_r     <= rd_addr;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (op == OP_LATCH) begin
      cmd_r <= in_cmd;
      id_r  <= in_entry_id;
      w_r   <= w_ext[WIDTH_BITS-1:0];
    end
    if (op == OP_LINK_A) old_head_r <= head_r;
    case (op)
      OP_LINK_B, OP_RSTART: begin
        sum_r     <= '0;
        pred_r    <= NIL;
      end
      OP_AWALK: begin
        if (!at_nil && !over) begin
          sum_r  <= sum_add;
          pred_r <= cur_r;
        end
      end
      OP_RWALK: begin
        if (!at_nil && !over) begin
          sum_r     <= sum_add;
          pend_id_r <= cur_r[IDW-1:0];
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r          <= '0;
      head_r             <= NIL;
      budget_r           <= '0;
      pend_valid_r       <= 1'b0;
      out_valid          <= 1'b0;
      out_report_id      <= '0;
      out_list_empty     <= 1'b0;
      out_last_of_report <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) budget_r <= cfg_wdata;
      case (op)
        OP_UNLINK: begin
          if (rd_prev_q == NIL) head_r <= rd_next_q;
          present_r[id_r[IDW-1:0]] <= 1'b0;
        end
        OP_LINK_A: begin
          present_r[id_r[IDW-1:0]] <= 1'b1;
          head_r                   <= id_link;
        end
        OP_AWALK: begin
          if (!at_nil && over) begin
            present_r[cur_r[IDW-1:0]] <= 1'b0;
            if (pred_r == NIL) head_r <= NIL;
          end
        end
        OP_EVICT: begin
          if (!at_nil) present_r[cur_r[IDW-1:0]] <= 1'b0;
        end
        OP_RSTART: pend_valid_r <= 1'b0;
        OP_RWALK: begin
          if (at_nil || over) begin
            out_valid          <= 1'b1;
            out_report_id      <= pend_valid_r ? ID_W'(pend_id_r) : '0;
            out_list_empty     <= !pend_valid_r;
            out_last_of_report <= 1'b1;
          end else begin
            out_valid          <= pend_valid_r;
            out_report_id      <= ID_W'(pend_id_r);
            out_list_empty     <= 1'b0;
            out_last_of_report <= 1'b0;
            pend_valid_r       <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/width_budget_recency_list_core.sv */
// ----------------------------------------------------------------------------
// width_budget_recency_list_core
// most-recent-first id list with a total width budget
// ----------------------------------------------------------------------------
// usage
//   command channel: an item (in_cmd, in_entry_id, in_entry_width) is taken
//   when start is high and busy is low
//   add: drops any old entry of the id, puts the new one at the front, then
//   walks from the front summing widths and evicts the first entry past
//   cfg budget and everything behind it
//   remove: unlinks the id if present; add and remove give no result
//   report: one result per listed id, most recent first, until the running
//   width would pass the budget; out_last_of_report marks the final one and
//   a report with nothing to list gives one result with out_list_empty set
// timing
//   results appear on out_* for one cycle each, marked by out_valid, in
//   consecutive cycles; the receiver cannot stall them
//   remove: reads the id's links, then unlinks it; add: unlinks any old entry,
//   links the id at the front, then walks; report: loads the head, then walks
//   the walk speed is set by the registered read port of the link memory,
//   one linked entry per cycle
// reset
//   synchronous, active low: list empty, budget zero, no item pending;
//   the link and width memories need no clearing
//   cfg_wdata is written whenever cfg_we is high; write only while idle
// ----------------------------------------------------------------------------
module width_budget_recency_list_core #(
  parameter int NUM_IDS    = 64,
  parameter int WIDTH_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [wbrl_pkg::CMD_W-1:0]    in_cmd,
  input  logic [wbrl_pkg::ID_W-1:0]     in_entry_id,
  input  logic [wbrl_pkg::IN_WID_W-1:0] in_entry_width,
  input  logic                          cfg_we,
  input  logic [wbrl_pkg::BUDGET_W-1:0] cfg_wdata,
  output logic                          out_valid,
  output logic [wbrl_pkg::ID_W-1:0]     out_report_id,
  output logic                          out_list_empty,
  output logic                          out_last_of_report
);
  import wbrl_pkg::*;

  op_t     op;
  status_t st;

  // sequencer: one state per step of a command
  wbrl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .op    (op)
  );

  // memories, head pointer, walk sum and result registers
  wbrl_datapath #(
    .NUM_IDS    (NUM_IDS),
    .WIDTH_BITS (WIDTH_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .op                 (op),
    .st                 (st),
    .in_cmd             (in_cmd),
    .in_entry_id        (in_entry_id),
    .in_entry_width     (in_entry_width),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_report_id      (out_report_id),
    .out_list_empty     (out_list_empty),
    .out_last_of_report (out_last_of_report)
  );

endmodule

/* hw/rtl/wbrl_checker.sv */
// ----------------------------------------------------------------------------
// wbrl_checker
// port level checks on the recency list core
// ----------------------------------------------------------------------------
module wbrl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [wbrl_pkg::ID_W-1:0]     out_report_id,
  input logic                          out_list_empty,
  input logic                          out_last_of_report
);

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");

  // an empty report is a single, final result with id zero
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_list_empty |-> out_last_of_report && out_report_id == '0)
    else $error("empty result malformed");

  // results of one report come in consecutive cycles
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_report |=> out_valid)
    else $error("gap inside report");

  // the final result is not followed at once by another
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_report |=> !out_valid)
    else $error("result right after final one");

endmodule

bind width_budget_recency_list_core wbrl_checker u_wbrl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_report_id      (out_report_id),
  .out_list_empty     (out_list_empty),
  .out_last_of_report (out_last_of_report)
);

/* dv/width_budget_recency_list_core_tb.sv */
// ----------------------------------------------------------------------------
// width_budget_recency_list_core_tb
// drives add, remove and report commands into the recency list core under
// several width budgets, predicts each report from its own copy of the list
// and checks every strobed result in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module width_budget_recency_list_core_tb;
  import wbrl_pkg::*;

  localparam int NUM_IDS    = 64;
  localparam int WD_LIMIT   = 3000;  // quiet cycles (no accepted item or result) before giving up
  localparam int DRAIN_WAIT = 100;   // longest add walk plus margin
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    in_cmd;
  logic [ID_W-1:0]     in_entry_id;
  logic [IN_WID_W-1:0] in_entry_width;
  logic                cfg_we;
  logic [BUDGET_W-1:0] cfg_wdata;
  logic                out_valid;
  logic [ID_W-1:0]     out_report_id;
  logic                out_list_empty;
  logic                out_last_of_report;

  width_budget_recency_list_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_entry_id       (in_entry_id),
    .in_entry_width    (in_entry_width),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_report_id     (out_report_id),
    .out_list_empty    (out_list_empty),
    .out_last_of_report(out_last_of_report)
  );

  // one listed entry as the block should report it
  typedef struct {
    logic [ID_W-1:0] rid;
    logic            empty;
    logic            last;
  } listing_t;

  // directed row: either a budget write or a command item; known rows carry
  // the single result typed in by hand
  typedef struct {
    bit                  is_cfg;
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     id;
    logic [IN_WID_W-1:0] wid;
    logic [BUDGET_W-1:0] budget;
    bit                  known;
    logic                k_empty;
    logic [ID_W-1:0]     k_id;
  } row_t;

  listing_t listing_q[$];
  int       fail_cnt;

  // ---------------------------------------------------------------------------
  // list shadow: doubly linked, most recent at the head, NUM_IDS marks nil
  // ---------------------------------------------------------------------------
  bit                  shadow_present[NUM_IDS];
  int                  shadow_next[NUM_IDS];
  int                  shadow_prev[NUM_IDS];
  logic [IN_WID_W-1:0] shadow_wid[NUM_IDS];
  int                  shadow_head;
  logic [BUDGET_W-1:0] shadow_budget;

  function automatic void drop_entry(int id);
    int nx, pv;
    if (!shadow_present[id]) return;
    nx = shadow_next[id];
    pv = shadow_prev[id];
    if (pv < NUM_IDS) shadow_next[pv] = nx;
    else shadow_head = nx;
    if (nx < NUM_IDS) shadow_prev[nx] = pv;
    shadow_present[id] = 0;
  endfunction

  function automatic void front_entry(int id, logic [IN_WID_W-1:0] w);
    int cur, nx;
    logic [31:0] sum;
    drop_entry(id);
    shadow_present[id] = 1;
    shadow_wid[id]     = w;
    shadow_prev[id]    = NUM_IDS;
    shadow_next[id]    = shadow_head;
    if (shadow_head < NUM_IDS) shadow_prev[shadow_head] = id;
    shadow_head = id;
    // find the first entry that breaks the budget, then evict it and the tail
    sum = 0;
    cur = shadow_head;
    while (cur < NUM_IDS) begin
      sum += shadow_wid[cur];
      if (sum > shadow_budget) break;
      cur = shadow_next[cur];
    end
    while (cur < NUM_IDS) begin
      nx = shadow_next[cur];
      drop_entry(cur);
      cur = nx;
    end
  endfunction

  // work out the listing a report must give and queue it
  function automatic void predict_listing();
    int cur, n;
    logic [31:0] sum;
    listing_t li;
    sum = 0;
    n   = 0;
    cur = shadow_head;
    while (cur < NUM_IDS && n < NUM_IDS) begin
      sum += shadow_wid[cur];
      if (sum > shadow_budget) break;
      li.rid   = cur[ID_W-1:0];
      li.empty = 1'b0;
      li.last  = 1'b0;
      listing_q.push_back(li);
      n++;
      cur = shadow_next[cur];
    end
    if (n == 0) begin
      li.rid   = '0;
      li.empty = 1'b1;
      li.last  = 1'b1;
      listing_q.push_back(li);
    end else begin
      listing_q[listing_q.size()-1].last = 1'b1;
    end
  endfunction

  function automatic void shadow_apply(logic [CMD_W-1:0] cmd, int id,
                                       logic [IN_WID_W-1:0] w);
    case (cmd)
      CMD_ADD:    front_entry(id, w);
      CMD_REMOVE: drop_entry(id);
      CMD_REPORT: predict_listing();
      default:    ;  // unused command leaves the list alone
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // result checker: every strobe pops the oldest expected listing
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    listing_t e;
    if (rst_n && out_valid) begin
      if (listing_q.size() == 0) begin
        $error("result with nothing expected: id %0d empty %0b last %0b",
               out_report_id, out_list_empty, out_last_of_report);
        fail_cnt++;
      end else begin
        e = listing_q.pop_front();
        if (out_list_empty !== e.empty) begin
          $error("list_empty: expected %0b actual %0b", e.empty, out_list_empty);
          fail_cnt++;
        end
        // report_id carries no meaning on an empty listing
        if (!e.empty && out_report_id !== e.rid) begin
          $error("report_id: expected %0d actual %0d", e.rid, out_report_id);
          fail_cnt++;
        end
        if (out_last_of_report !== e.last) begin
          $error("last_of_report: expected %0b actual %0b", e.last, out_last_of_report);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: counts cycles with neither an accepted item nor a result
  // ---------------------------------------------------------------------------
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("width_budget_recency_list_core_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  int idle_pct;

  // present one item and hold it until the block takes it; start stays high
  // afterwards unless an idle gap follows
  task automatic issue(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                       logic [IN_WID_W-1:0] w);
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_entry_id    <= id;
    in_entry_width <= w;
    do @(posedge clk); while (busy);
    shadow_apply(cmd, id, w);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // budget write: only once every result is in and the last add has finished
  task automatic set_budget(logic [BUDGET_W-1:0] b);
    start <= 1'b0;
    while (listing_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we        <= 1'b0;
    shadow_budget  = b;
  endtask

  row_t directed[$];

  function automatic row_t mk_item(logic [CMD_W-1:0] c, int id, int w);
    row_t r;
    r = '{default: '0};
    r.cmd = c;
    r.id  = ID_W'(id);
    r.wid = IN_WID_W'(w);
    return r;
  endfunction

  function automatic row_t mk_known(logic em, int id);
    row_t r;
    r = mk_item(CMD_REPORT, 0, 0);
    r.known   = 1;
    r.k_empty = em;
    r.k_id    = ID_W'(id);
    return r;
  endfunction

  function automatic row_t mk_cfg(int b);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.budget = BUDGET_W'(b);
    return r;
  endfunction

  logic [CMD_W-1:0]    r_cmd;
  logic [ID_W-1:0]     r_id;
  logic [IN_WID_W-1:0] r_w;
  int                  sel;
  int                  budgets[6];
  int                  idles[6];
  listing_t            typed;

  initial begin
    fail_cnt       = 0;
    idle_pct       = 35;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_cmd         = CMD_ADD;
    in_entry_id    = '0;
    in_entry_width = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    for (int i = 0; i < NUM_IDS; i++) begin
      shadow_present[i] = 0;
      shadow_next[i]    = NUM_IDS;
      shadow_prev[i]    = NUM_IDS;
      shadow_wid[i]     = '0;
    end
    shadow_head   = NUM_IDS;
    shadow_budget = '0;

    // budget zero after reset: only zero-width entries survive
    directed.push_back(mk_known(1'b1, 0));            // empty list after reset
    directed.push_back(mk_item(CMD_ADD, 5, 0));
    directed.push_back(mk_known(1'b0, 5));            // zero width fits a zero budget
    directed.push_back(mk_item(CMD_ADD, 63, 16'hffff)); // evicts itself and the rest
    directed.push_back(mk_known(1'b1, 0));
    directed.push_back(mk_item(CMD_UNUSED, 7, 16'h1234));
    directed.push_back(mk_item(CMD_REMOVE, 9, 0));    // absent id
    // widest budget, widest entries, re-add moves an id to the front
    directed.push_back(mk_cfg(20'hfffff));
    directed.push_back(mk_item(CMD_ADD, 0, 16'hffff));
    directed.push_back(mk_item(CMD_ADD, 63, 16'hffff));
    directed.push_back(mk_item(CMD_ADD, 1, 100));
    directed.push_back(mk_item(CMD_ADD, 0, 5));
    directed.push_back(mk_item(CMD_REPORT, 0, 0));
    directed.push_back(mk_item(CMD_REMOVE, 63, 0));
    directed.push_back(mk_item(CMD_REMOVE, 63, 0));
    directed.push_back(mk_item(CMD_REPORT, 0, 0));
    // the front entry alone past the budget
    directed.push_back(mk_cfg(100));
    directed.push_back(mk_item(CMD_ADD, 2, 101));
    directed.push_back(mk_known(1'b1, 0));
    // tail eviction when the sum crosses the budget
    directed.push_back(mk_cfg(300));
    directed.push_back(mk_item(CMD_ADD, 3, 200));
    directed.push_back(mk_item(CMD_ADD, 4, 150));
    directed.push_back(mk_item(CMD_REPORT, 0, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        set_budget(directed[i].budget);
      end else if (directed[i].known) begin
        // typed expectation replaces the predicted one
        issue(directed[i].cmd, directed[i].id, directed[i].wid);
        void'(listing_q.pop_back());
        typed.rid   = directed[i].k_id;
        typed.empty = directed[i].k_empty;
        typed.last  = 1'b1;
        listing_q.push_back(typed);
      end else begin
        issue(directed[i].cmd, directed[i].id, directed[i].wid);
      end
    end

    // random phases, each under its own budget and sender idle rate
    budgets = '{20'hfffff, $urandom_range(1000, 300000), 0, 65535,
                $urandom_range(0, 20'hfffff), 20'hfffff};
    idles   = '{35, 35, 72, 72, 0, 0};
    for (int ph = 0; ph < 6; ph++) begin
      set_budget(BUDGET_W'(budgets[ph]));
      idle_pct = idles[ph];
      for (int k = 0; k < 55; k++) begin
        sel = $urandom_range(99);
        if (sel < 5) r_cmd = CMD_UNUSED;
        else if (sel < 55) r_cmd = CMD_ADD;
        else if (sel < 72) r_cmd = CMD_REMOVE;
        else r_cmd = CMD_REPORT;
        // a small id pool gives frequent re-adds and removes of present ids
        r_id = ID_W'(($urandom_range(1)) ? $urandom_range(0, 15) : $urandom_range(0, 63));
        sel = $urandom_range(99);
        if (sel < 20) r_w = IN_WID_W'($urandom_range(0, 16'hffff));
        else if (sel < 30) r_w = 16'hffff;
        else r_w = IN_WID_W'($urandom_range(0, 4000));
        issue(r_cmd, r_id, r_w);
      end
    end

    start <= 1'b0;
    while (listing_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("width_budget_recency_list_core_tb passed");
    end else begin
      $display("width_budget_recency_list_core_tb failed");
    end
    $finish;
  end

endmodule
